// ----- src/thlin_pkg.sv -----
// Shared types, calibration tables and register codes for the thermistor linearizer.
// No dependencies; imported by the linearizer top level.
package thlin_pkg;

    localparam int TABLE_POINTS   = 19;
    localparam int ADC_BITS       = 10;
    localparam int SEG_COUNT      = TABLE_POINTS - 1;
    localparam int PT_BITS        = $clog2(TABLE_POINTS);
    localparam int SEG_BITS       = $clog2(SEG_COUNT);
    localparam int TEMP_BITS      = 9;
    localparam int F_BITS         = 10;
    localparam int DT_BITS        = 8;
    localparam int PROD_BITS      = ADC_BITS + DT_BITS;
    localparam int RECIP_BITS     = 16;
    localparam int RECIP_SHIFT    = 16;
    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS  = 10;

    // Celsius to Fahrenheit: floor(t * 9 / 5) equals (t * F_MULT) >> F_SHIFT for
    // every t in 0..255, with F_MULT = 9 * ceil(2^16 / 5).
    localparam int F_MULT      = 117972;
    localparam int F_MULT_BITS = 17;
    localparam int F_SHIFT     = 16;
    localparam int F_OFFSET    = 32;
    localparam int FAULT_TEMP  = -128;

    localparam int RST_ADC_LOW   = 15;
    localparam int RST_ADC_HIGH  = 650;
    localparam int RST_TEMP_LOW  = 0;
    localparam int RST_TEMP_HIGH = 140;
    localparam int RST_OVERHEAT  = 130;

    typedef logic [ADC_BITS-1:0]          adc_t;
    typedef logic signed [TEMP_BITS-1:0]  temp_t;
    typedef logic signed [F_BITS-1:0]     tempf_t;
    typedef logic [PT_BITS-1:0]           pt_t;
    typedef logic [DT_BITS-1:0]           dt_t;
    typedef logic [PROD_BITS-1:0]         prod_t;
    typedef logic [RECIP_BITS-1:0]        recip_t;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_ADC_LOW,
        CFG_ADC_HIGH,
        CFG_TEMP_LOW,
        CFG_TEMP_HIGH,
        CFG_OVERHEAT
    } cfg_index_t;

    // Descending converter codes and the matching Celsius points.
    localparam adc_t CAL_ADC [TABLE_POINTS] = '{
        600, 523, 450, 380, 320, 270, 230, 195, 165, 140,
        120, 100, 85, 70, 65, 52, 40, 30, 20
    };
    localparam temp_t CAL_TEMP [TABLE_POINTS] = '{
        15, 20, 25, 30, 35, 40, 45, 50, 55, 60,
        65, 70, 75, 80, 88, 100, 110, 120, 130
    };

    // floor(2^16 / span) for each segment, where span is the code distance
    // between its two points. The quotient estimate is low by at most one.
    localparam recip_t SEG_RECIP [SEG_COUNT] = '{
        851, 897, 936, 1092, 1310, 1638, 1872, 2184, 2621,
        3276, 3276, 4369, 4369, 13107, 5041, 5461, 6553, 6553
    };

endpackage

// ----- src/thermistor_adc_linearizer_top.sv -----
// Top level of the thermistor linearizer: window checks, segment lookup and
// five-stage interpolation pipeline. Depends on thlin_pkg.
//
// Throughput: one beat per clock while out_stall is low; the pipeline is set by one
// register stage per arithmetic step (segment search, product, reciprocal multiply,
// correction, output). Reset: rst_n clears all stage valid bits and loads the limit
// registers with their defaults; payload registers are not reset.
module thermistor_adc_linearizer_top
    import thlin_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,

    input  logic                      cfg_we,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  cfg_data,

    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic [ADC_BITS-1:0]       adc_sample,

    output logic                      out_valid,
    input  logic                      out_stall,
    output logic signed [TEMP_BITS-1:0] temp_c,
    output logic                      reading_valid,
    output logic signed [F_BITS-1:0]  temp_f,
    output logic                      over_temp
);

    // Limit registers. They are to be written only while the pipeline is empty; the block itself does not enforce this.
    adc_t  adc_low_reg;
    adc_t  adc_high_reg;
    temp_t temp_low_reg;
    temp_t temp_high_reg;
    temp_t overheat_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            adc_low_reg   <= adc_t'(RST_ADC_LOW);
            adc_high_reg  <= adc_t'(RST_ADC_HIGH);
            temp_low_reg  <= temp_t'(RST_TEMP_LOW);
            temp_high_reg <= temp_t'(RST_TEMP_HIGH);
            overheat_reg  <= temp_t'(RST_OVERHEAT);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_ADC_LOW:   adc_low_reg   <= cfg_data[ADC_BITS-1:0];
                CFG_ADC_HIGH:  adc_high_reg  <= cfg_data[ADC_BITS-1:0];
                CFG_TEMP_LOW:  temp_low_reg  <= $signed(cfg_data[TEMP_BITS-1:0]);
                CFG_TEMP_HIGH: temp_high_reg <= $signed(cfg_data[TEMP_BITS-1:0]);
                CFG_OVERHEAT:  overheat_reg  <= $signed(cfg_data[TEMP_BITS-1:0]);
                default:       ;
            endcase
        end
    end

    // Stage valid bits and the per-stage advance conditions. A stage loads
    // when it is empty or when the stage after it moves, so bubbles collapse
    // and an input beat is refused only when every stage holds an item and out_stall is high.
    logic v1_reg, v2_reg, v3_reg, v4_reg, out_valid_reg;
    logic rdy1, rdy2, rdy3, rdy4, rdy5;

    assign rdy5 = !out_valid_reg || !out_stall;
    assign rdy4 = !v4_reg || rdy5;
    assign rdy3 = !v3_reg || rdy4;
    assign rdy2 = !v2_reg || rdy3;
    assign rdy1 = !v1_reg || rdy2;

    assign in_stall  = !rdy1;
    assign out_valid = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            v4_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (rdy1) v1_reg        <= in_valid;
            if (rdy2) v2_reg        <= v1_reg;
            if (rdy3) v3_reg        <= v2_reg;
            if (rdy4) v4_reg        <= v3_reg;
            if (rdy5) out_valid_reg <= v4_reg;
        end
    end

    // Stage 1: ADC window check and segment search. A sample at or above the
    // first point is mapped to the first segment with no offset; one at or
    // below the last point is mapped to the last segment with its full span,
    // which lands exactly on the last point's temperature. Otherwise the
    // first segment whose lower code does not exceed the sample is taken.
    logic adc_ok_next;
    pt_t  seg_next;
    adc_t diff_next;

    always_comb
    begin
        adc_ok_next = (adc_sample >= adc_low_reg) && (adc_sample <= adc_high_reg);
        seg_next    = pt_t'(SEG_COUNT - 1);
        diff_next   = '0;
        priority if (adc_sample >= CAL_ADC[0])
        begin
            seg_next  = '0;
            diff_next = '0;
        end
        else if (adc_sample <= CAL_ADC[TABLE_POINTS-1])
        begin
            seg_next  = pt_t'(SEG_COUNT - 1);
            diff_next = CAL_ADC[TABLE_POINTS-2] - CAL_ADC[TABLE_POINTS-1];
        end
        else
        begin
            for (int i = SEG_COUNT - 1; i >= 0; i--)
            begin
                if (adc_sample >= CAL_ADC[i+1])
                begin
                    seg_next  = pt_t'(i);
                    diff_next = CAL_ADC[i] - adc_sample;
                end
            end
        end
    end

    logic adc_ok1_reg;
    pt_t  seg1_reg;
    adc_t diff1_reg;

    always_ff @(posedge clk)
    begin
        if (rdy1)
        begin
            adc_ok1_reg <= adc_ok_next;
            seg1_reg    <= seg_next;
            diff1_reg   <= diff_next;
        end
    end

    // Stage 2: numerator = code offset times the segment's temperature step.
    dt_t   dt2;
    prod_t num_next;

    always_comb
    begin
        dt2      = dt_t'(CAL_TEMP[seg1_reg + pt_t'(1)] - CAL_TEMP[seg1_reg]);
        num_next = prod_t'(diff1_reg) * prod_t'(dt2);
    end

    logic  adc_ok2_reg;
    pt_t   seg2_reg;
    prod_t num2_reg;

    always_ff @(posedge clk)
    begin
        if (rdy2)
        begin
            adc_ok2_reg <= adc_ok1_reg;
            seg2_reg    <= seg1_reg;
            num2_reg    <= num_next;
        end
    end

    // Stage 3: quotient estimate by the segment's reciprocal.
    logic [PROD_BITS+RECIP_BITS-1:0] recip_prod;
    prod_t                           quot_est_next;

    always_comb
    begin
        recip_prod    = (PROD_BITS+RECIP_BITS)'(num2_reg)
                      * (PROD_BITS+RECIP_BITS)'(SEG_RECIP[seg2_reg[SEG_BITS-1:0]]);
        quot_est_next = prod_t'(recip_prod >> RECIP_SHIFT);
    end

    logic  adc_ok3_reg;
    pt_t   seg3_reg;
    prod_t num3_reg;
    prod_t quot3_reg;

    always_ff @(posedge clk)
    begin
        if (rdy3)
        begin
            adc_ok3_reg <= adc_ok2_reg;
            seg3_reg    <= seg2_reg;
            num3_reg    <= num2_reg;
            quot3_reg   <= quot_est_next;
        end
    end

    // Stage 4: the estimate may be one short; fix it with the remainder and
    // add the quotient to the temperature at the segment's higher-code point.
    adc_t                          span4;
    logic [PROD_BITS+ADC_BITS-1:0] quot_span;
    prod_t                         rem4;
    prod_t                         quot4;
    temp_t                         temp_next;

    always_comb
    begin
        span4     = CAL_ADC[seg3_reg] - CAL_ADC[seg3_reg + pt_t'(1)];
        quot_span = (PROD_BITS+ADC_BITS)'(quot3_reg) * (PROD_BITS+ADC_BITS)'(span4);
        rem4      = num3_reg - prod_t'(quot_span);
        quot4     = (rem4 >= prod_t'(span4)) ? quot3_reg + prod_t'(1) : quot3_reg;
        temp_next = CAL_TEMP[seg3_reg] + $signed({1'b0, quot4[TEMP_BITS-2:0]});
    end

    logic  adc_ok4_reg;
    temp_t temp4_reg;

    always_ff @(posedge clk)
    begin
        if (rdy4)
        begin
            adc_ok4_reg <= adc_ok3_reg;
            temp4_reg   <= temp_next;
        end
    end

    // Stage 5: temperature window, overheat flag, Fahrenheit conversion and fault sentinel.
    // Interpolated temperatures are never negative, so the conversion works
    // on the magnitude bits.
    logic                                  ok_next;
    logic [TEMP_BITS-1+F_MULT_BITS-1:0]    f_prod;
    tempf_t                                temp_f_next;
    temp_t                                 temp_c_next;
    logic                                  over_next;

    always_comb
    begin
        ok_next     = adc_ok4_reg && (temp4_reg >= temp_low_reg)
                    && (temp4_reg <= temp_high_reg);
        f_prod      = (TEMP_BITS-1+F_MULT_BITS)'(temp4_reg[TEMP_BITS-2:0])
                    * (TEMP_BITS-1+F_MULT_BITS)'(F_MULT);
        temp_f_next = tempf_t'(FAULT_TEMP);
        temp_c_next = temp_t'(FAULT_TEMP);
        over_next   = 1'b1;
        if (ok_next)
        begin
            temp_f_next = tempf_t'(f_prod >> F_SHIFT) + tempf_t'(F_OFFSET);
            temp_c_next = temp4_reg;
            over_next   = (temp4_reg >= overheat_reg);
        end
    end

    temp_t  temp_c_reg;
    tempf_t temp_f_reg;
    logic   reading_valid_reg;
    logic   over_temp_reg;

    always_ff @(posedge clk)
    begin
        if (rdy5)
        begin
            temp_c_reg        <= temp_c_next;
            temp_f_reg        <= temp_f_next;
            reading_valid_reg <= ok_next;
            over_temp_reg     <= over_next;
        end
    end

    assign temp_c        = temp_c_reg;
    assign temp_f        = temp_f_reg;
    assign reading_valid = reading_valid_reg;
    assign over_temp     = over_temp_reg;

`ifndef SYNTHESIS
    // Input is refused only when every stage is occupied and the output waits.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (v1_reg && v2_reg && v3_reg && v4_reg && out_valid_reg && out_stall))
        else $error("input stalled while the pipeline has a free stage");

    // The interpolated temperature stays between the table's end points.
    assert property (@(posedge clk) disable iff (!rst_n)
        v4_reg |-> (temp4_reg >= CAL_TEMP[0] && temp4_reg <= CAL_TEMP[TABLE_POINTS-1]))
        else $error("interpolated temperature outside the calibration range");

    // A faulty reading carries the sentinel and the over-temperature flag.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !reading_valid) |->
            (temp_c == temp_t'(FAULT_TEMP) && temp_f == tempf_t'(FAULT_TEMP) && over_temp))
        else $error("fault result without sentinel");

    // A valid reading lies inside the temperature window.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && reading_valid) |->
            (temp_c >= temp_low_reg && temp_c <= temp_high_reg))
        else $error("valid reading outside the temperature window");
`endif

endmodule

// ----- tb/sv/thermistor_adc_linearizer_top_tb.sv -----
// Self-checking testbench for thermistor_adc_linearizer_top: converter samples in, Celsius,
// Fahrenheit and status flags out, compared beat by beat against typed rows or a behavioral predictor.
// Depends on thlin_pkg and the linearizer top level; needs no other files.
`timescale 1ns / 1ps

module thermistor_adc_linearizer_top_tb;
    import thlin_pkg::*;

    // Number of register stages in the top level. It is used only to drain
    // the pipeline before limit registers are rewritten and at the end of the run.
    localparam int PIPE_DEPTH = 5;
    localparam int LAST_KNEE  = 18;
    // Register indexes above the last defined limit register are spare and must be ignored.
    localparam int FIRST_SPARE = int'(CFG_OVERHEAT) + 1;
    localparam int LAST_SPARE  = (1 << CFG_INDEX_BITS) - 1;

    // Calibration curve of the sensor divider: descending converter codes and the
    // Celsius value at each knee.
    localparam int KNEE_CODE [LAST_KNEE+1] = '{
        600, 523, 450, 380, 320, 270, 230, 195, 165, 140,
        120, 100, 85, 70, 65, 52, 40, 30, 20
    };
    localparam int KNEE_DEGC [LAST_KNEE+1] = '{
        15, 20, 25, 30, 35, 40, 45, 50, 55, 60,
        65, 70, 75, 80, 88, 100, 110, 120, 130
    };

    // One result beat, in port order.
    typedef struct packed {
        temp_t  celsius;
        logic   ok;
        tempf_t fahrenheit;
        logic   hot;
    } reading_t;

    // A faulty reading reports the sentinel on both scales and forces the overheat flag.
    localparam reading_t FAULT_READING = '{
        celsius: temp_t'(FAULT_TEMP), ok: 1'b0, fahrenheit: tempf_t'(FAULT_TEMP), hot: 1'b1
    };

    // A directed row carries its expected reading only when "typed" is set; otherwise
    // the predictor supplies it.
    typedef struct packed {
        adc_t     sample;
        logic     typed;
        reading_t result;
    } vector_t;

    localparam int NUM_DIRECTED = 24;

    // Directed rows, all run with the limit registers at their reset values
    // (ADC window 15..650, Celsius window 0..140, overheat at 130).
    vector_t directed_vecs [NUM_DIRECTED] = '{
        '{10'd0,    1'b1, FAULT_READING},                 // bottom code, shorted sensor
        '{10'd14,   1'b1, FAULT_READING},                 // just below the ADC window
        '{10'd15,   1'b1, '{9'sd130, 1'b1, 10'sd266, 1'b1}},  // window edge, clamped hot end
        '{10'd16,   1'b1, '{9'sd130, 1'b1, 10'sd266, 1'b1}},
        '{10'd20,   1'b1, '{9'sd130, 1'b1, 10'sd266, 1'b1}},  // last knee exactly
        '{10'd21,   1'b0, '0},
        '{10'd30,   1'b0, '0},
        '{10'd52,   1'b0, '0},
        '{10'd64,   1'b0, '0},
        '{10'd65,   1'b1, '{9'sd88, 1'b1, 10'sd190, 1'b0}},   // knee with the short segment
        '{10'd66,   1'b0, '0},
        '{10'd69,   1'b0, '0},
        '{10'd140,  1'b0, '0},
        '{10'd341,  1'b0, '0},
        '{10'd522,  1'b0, '0},
        '{10'd523,  1'b1, '{9'sd20, 1'b1, 10'sd68, 1'b0}},    // knee exactly
        '{10'd524,  1'b0, '0},
        '{10'd599,  1'b0, '0},
        '{10'd600,  1'b1, '{9'sd15, 1'b1, 10'sd59, 1'b0}},    // first knee, cold end
        '{10'd601,  1'b1, '{9'sd15, 1'b1, 10'sd59, 1'b0}},    // above the curve, clamped
        '{10'd650,  1'b1, '{9'sd15, 1'b1, 10'sd59, 1'b0}},    // top edge of the ADC window
        '{10'd651,  1'b1, FAULT_READING},                 // open circuit
        '{10'd682,  1'b1, FAULT_READING},
        '{10'd1023, 1'b1, FAULT_READING}                  // top code
    };

    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      cfg_we = 1'b0;
    logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
    logic [CFG_DATA_BITS-1:0]  cfg_data = '0;
    logic                      in_valid = 1'b0;
    logic                      in_stall;
    logic [ADC_BITS-1:0]       adc_sample = '0;
    logic                      out_valid;
    logic                      out_stall = 1'b0;
    logic signed [TEMP_BITS-1:0] temp_c;
    logic                      reading_valid;
    logic signed [F_BITS-1:0]  temp_f;
    logic                      over_temp;

    // Expected reading of the beat currently offered on the input. It moves with the
    // payload, so the scoreboard picks it up at the edge where the beat is accepted.
    reading_t beat_result = '0;
    reading_t awaited_readings [$];

    // Predictor copy of the limit registers, starting at their reset values.
    int lim_adc_low   = 15;
    int lim_adc_high  = 650;
    int lim_temp_low  = 0;
    int lim_temp_high = 140;
    int lim_overheat  = 130;

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int n_sent     = 0;
    int n_checked  = 0;
    int n_errors   = 0;
    int n_settings = 0;

    thermistor_adc_linearizer_top DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .adc_sample    (adc_sample),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .temp_c        (temp_c),
        .reading_valid (reading_valid),
        .temp_f        (temp_f),
        .over_temp     (over_temp)
    );

    always #2 clk = ~clk;

    // Temperature for one sample under the current limits. Between two knees the
    // value is interpolated with a divide that truncates toward zero; beyond the
    // ends of the curve it is clamped to the end temperature.
    function automatic reading_t predict_reading(input adc_t sample);
        int code;
        int degc;
        int seg;
        reading_t r;
        code = int'(sample);
        r = FAULT_READING;
        if (code >= lim_adc_low && code <= lim_adc_high)
        begin
            if (code >= KNEE_CODE[0])
                degc = KNEE_DEGC[0];
            else if (code <= KNEE_CODE[LAST_KNEE])
                degc = KNEE_DEGC[LAST_KNEE];
            else
            begin
                degc = KNEE_DEGC[LAST_KNEE];
                // Walking downward leaves the lowest matching segment, which is the
                // one the first-match search picks; a knee gives the same value in both.
                for (seg = LAST_KNEE - 1; seg >= 0; seg--)
                begin
                    if (code >= KNEE_CODE[seg+1] && code <= KNEE_CODE[seg])
                        degc = KNEE_DEGC[seg] + ((code - KNEE_CODE[seg])
                               * (KNEE_DEGC[seg+1] - KNEE_DEGC[seg]))
                               / (KNEE_CODE[seg+1] - KNEE_CODE[seg]);
                end
            end
            if (degc >= lim_temp_low && degc <= lim_temp_high)
            begin
                r.celsius    = temp_t'(degc);
                r.ok         = 1'b1;
                r.fahrenheit = tempf_t'(degc * 9 / 5 + 32);
                r.hot        = (degc >= lim_overheat);
            end
        end
        return r;
    endfunction

    // Random samples lean toward the interesting part of the code range: a share
    // anywhere in the 10-bit range, a share on or next to a knee, the rest in and
    // just around the default ADC window.
    function automatic adc_t pick_sample();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 15)
            return adc_t'($urandom_range(0, 1023));
        if (roll < 40)
            return adc_t'(KNEE_CODE[$urandom_range(0, LAST_KNEE)] + $urandom_range(0, 2) - 1);
        return adc_t'($urandom_range(0, 660));
    endfunction

    // The receiver stalls on a random share of the cycles, independent of out_valid.
    always @(posedge clk)
        out_stall <= ($urandom_range(0, 99) < recv_stall_pct);

    // Scoreboard. Values are read at the edge, before this edge's updates land, so a
    // beat counts exactly when valid was high and stall low just before the edge.
    always @(posedge clk)
    begin : scoreboard
        reading_t got;
        reading_t want;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                got = '{temp_c, reading_valid, temp_f, over_temp};
                if (awaited_readings.size() == 0)
                begin
                    $display("%0t: result beat with no reading expected: temp_c %0d",
                             $time, got.celsius);
                    n_errors++;
                end
                else
                begin
                    want = awaited_readings.pop_front();
                    n_checked++;
                    if (got.celsius !== want.celsius)
                    begin
                        $display("%0t: temp_c expected %0d, got %0d",
                                 $time, want.celsius, got.celsius);
                        n_errors++;
                    end
                    if (got.ok !== want.ok)
                    begin
                        $display("%0t: reading_valid expected %0b, got %0b",
                                 $time, want.ok, got.ok);
                        n_errors++;
                    end
                    if (got.fahrenheit !== want.fahrenheit)
                    begin
                        $display("%0t: temp_f expected %0d, got %0d",
                                 $time, want.fahrenheit, got.fahrenheit);
                        n_errors++;
                    end
                    if (got.hot !== want.hot)
                    begin
                        $display("%0t: over_temp expected %0b, got %0b",
                                 $time, want.hot, got.hot);
                        n_errors++;
                    end
                end
            end
            if (in_valid && !in_stall)
                awaited_readings.push_back(beat_result);
        end
    end

    // Offers one sample beat, after a random number of idle cycles, and holds it
    // steady until the block takes it. in_valid is left high on return so that
    // back-to-back beats keep in_valid high between them.
    task automatic push_beat(input adc_t sample, input reading_t result);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid    <= 1'b1;
        adc_sample  <= sample;
        beat_result <= result;
        do
            @(posedge clk);
        while (in_stall);
        n_sent++;
    endtask

    // Waits until every expected reading has come back, then lets the pipeline empty.
    // The first edge lets the scoreboard record the final accepted beat.
    task automatic settle();
        do
            @(posedge clk);
        while (awaited_readings.size() != 0);
        repeat (PIPE_DEPTH + 2) @(posedge clk);
    endtask

    // One register write; the predictor copy follows at the same edge. Spare indexes
    // leave every limit untouched. Temperature registers keep only nine bits.
    task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                             input logic [CFG_DATA_BITS-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        case (idx)
            CFG_ADC_LOW:   lim_adc_low   = int'(data);
            CFG_ADC_HIGH:  lim_adc_high  = int'(data);
            CFG_TEMP_LOW:  lim_temp_low  = int'(temp_t'(data[TEMP_BITS-1:0]));
            CFG_TEMP_HIGH: lim_temp_high = int'(temp_t'(data[TEMP_BITS-1:0]));
            CFG_OVERHEAT:  lim_overheat  = int'(temp_t'(data[TEMP_BITS-1:0]));
            default: ;
        endcase
    endtask

    // Loads all five limits. The unused top data bit of the temperature registers
    // gets a random value, which the block must ignore.
    task automatic program_limits(input int adc_lo, input int adc_hi, input int t_lo,
                                  input int t_hi, input int hot_at);
        write_reg(CFG_ADC_LOW,   adc_lo[CFG_DATA_BITS-1:0]);
        write_reg(CFG_ADC_HIGH,  adc_hi[CFG_DATA_BITS-1:0]);
        write_reg(CFG_TEMP_LOW,  {1'($urandom_range(0, 1)), t_lo[TEMP_BITS-1:0]});
        write_reg(CFG_TEMP_HIGH, {1'($urandom_range(0, 1)), t_hi[TEMP_BITS-1:0]});
        write_reg(CFG_OVERHEAT,  {1'($urandom_range(0, 1)), hot_at[TEMP_BITS-1:0]});
        cfg_we <= 1'b0;
        n_settings++;
    endtask

    // A burst of random samples under the current limits, then a full drain so the
    // next limit change happens with the block idle.
    task automatic run_random(input int count);
        adc_t sample;
        repeat (count)
        begin
            sample = pick_sample();
            push_beat(sample, predict_reading(sample));
        end
        in_valid <= 1'b0;
        settle();
    endtask

    initial
    begin : stimulus
        int k;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Sender idles often, receiver stalls more often still; limits at reset values.
        send_idle_pct  = 34;
        recv_stall_pct = 53;
        n_settings     = 1;
        for (k = 0; k < NUM_DIRECTED; k++)
            push_beat(directed_vecs[k].sample,
                      directed_vecs[k].typed ? directed_vecs[k].result
                                             : predict_reading(directed_vecs[k].sample));
        run_random(380);

        // Widest windows: every code passes the ADC check, every curve value passes
        // the Celsius check, and the overheat limit at its floor flags every reading.
        send_idle_pct  = 53;
        recv_stall_pct = 34;
        program_limits(0, 1023, -128, 255, -128);
        run_random(300);

        // Inverted ADC window, so every sample is a fault. A write to a spare index
        // goes first and must change nothing.
        write_reg(3'(FIRST_SPARE + $urandom_range(0, LAST_SPARE - FIRST_SPARE)),
                  10'($urandom_range(0, 1023)));
        program_limits(651, 14, 0, 140, 130);
        run_random(60);

        // Inverted Celsius window with the overheat limit at its ceiling.
        program_limits(0, 1023, 131, 14, 255);
        run_random(60);

        // No idling on either side; random limits that cut through the curve.
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        repeat (5)
        begin
            program_limits($urandom_range(0, 200), $urandom_range(300, 1023),
                           int'($urandom_range(0, 200)) - 128, $urandom_range(60, 255),
                           int'($urandom_range(0, 383)) - 128);
            run_random(160);
        end

        $display("Sent %0d sample beats under %0d limit settings across three pacing modes;",
                 n_sent, n_settings);
        $display("checked %0d result beats and found %0d mismatches.", n_checked, n_errors);
        if (n_errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    // Watchdog: a correct run finishes in a small fraction of this time, so reaching
    // it means a beat or a result got stuck.
    initial
    begin
        #2000000;
        $display("Timeout with %0d readings still expected.", awaited_readings.size());
        $display("CHECKS FAILED");
        $finish;
    end

endmodule

// ----- files.f -----
src/thlin_pkg.sv
src/thermistor_adc_linearizer_top.sv
tb/sv/thermistor_adc_linearizer_top_tb.sv
